// File: hdl/nnsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// nnsa_pkg
// shared types, constants and helpers of the nearest-neighbor scaler address
// generator
// ----------------------------------------------------------------------------
package nnsa_pkg;

   localparam int MAX_DIM   = 4096;
   localparam int ADDR_BITS = 32;
   localparam int DIM_W     = $clog2(MAX_DIM) + 1;   // size register / effective size
   localparam int COORD_W   = 12;
   localparam int BPP_W     = 3;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 32;

   // configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SOURCE_WIDTH    = 3'd0,
      CSR_SOURCE_HEIGHT   = 3'd1,
      CSR_TARGET_WIDTH    = 3'd2,
      CSR_TARGET_HEIGHT   = 3'd3,
      CSR_BYTES_PER_PIXEL = 3'd4,
      CSR_SOURCE_BASE     = 3'd5,
      CSR_TARGET_BASE     = 3'd6
   } csr_index_type;

   typedef struct packed {
      logic [COORD_W-1:0] column;
      logic [COORD_W-1:0] line;
   } req_type;

   typedef struct packed {
      logic [ADDR_BITS-1:0] read_address;
      logic [ADDR_BITS-1:0] write_address;
      logic                 enlarging;
   } rsp_type;

   // zero reads as one, anything above the maximum reads as the maximum
   function automatic logic [DIM_W-1:0] eff_size(input logic [DIM_W-1:0] v);
      logic [DIM_W-1:0] r;
      r = v;
      if (v == '0) begin
         r = DIM_W'(1);
      end else if (v > DIM_W'(MAX_DIM)) begin
         r = DIM_W'(MAX_DIM);
      end
      return r;
   endfunction

endpackage : nnsa_pkg
`default_nettype wire

// File: hdl/nearest_neighbor_scale_address.sv
`timescale 1ns / 1ps
`default_nettype none
// throughput: one request per cycle while rsp_stall stays low; seven register stages
//   (offset, multiply, two halves of the 12-step divider, clamp, index multiply,
//   address) each advance when empty or when the next stage moves, so a stalled
//   stage holds while empty stages fill
// reset: sizes and bytes_per_pixel return to 1, bases to 0, pipeline empties
// mixed scaling (one axis grows, the other shrinks) gives no result
// ----------------------------------------------------------------------------
// nearest_neighbor_scale_address
// centre-anchored nearest-neighbor scaler address generator: maps one pixel
// coordinate onto the other image and returns source and destination
// byte addresses
// ----------------------------------------------------------------------------
module nearest_neighbor_scale_address
   import nnsa_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // request channel
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire req_type              req_data,
   // result channel
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output rsp_type                   rsp_data,
   // configuration port
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CSR_DAT_W-1:0] csr_data
);

   localparam int NSTG  = 7;
   localparam int PROD_W = COORD_W + DIM_W;   // |offset| * size
   localparam int HALF_Q = COORD_W / 2;       // quotient bits per divider stage
   localparam int IDX_W  = 2 * COORD_W;       // row * width + column
   localparam int SCL_W  = IDX_W + BPP_W;

   // -------------------------------------------------------------------------
   // configuration registers
   // -------------------------------------------------------------------------
   logic [DIM_W-1:0]     src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [BPP_W-1:0]     bpp_ff;
   logic [ADDR_BITS-1:0] src_base_ff, dst_base_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         src_w_ff    <= DIM_W'(1);
         src_h_ff    <= DIM_W'(1);
         dst_w_ff    <= DIM_W'(1);
         dst_h_ff    <= DIM_W'(1);
         bpp_ff      <= BPP_W'(1);
         src_base_ff <= '0;
         dst_base_ff <= '0;
      end else if (csr_write) begin
         unique case (csr_index)
            CSR_SOURCE_WIDTH:    src_w_ff    <= csr_data[DIM_W-1:0];
            CSR_SOURCE_HEIGHT:   src_h_ff    <= csr_data[DIM_W-1:0];
            CSR_TARGET_WIDTH:    dst_w_ff    <= csr_data[DIM_W-1:0];
            CSR_TARGET_HEIGHT:   dst_h_ff    <= csr_data[DIM_W-1:0];
            CSR_BYTES_PER_PIXEL: bpp_ff      <= csr_data[BPP_W-1:0];
            CSR_SOURCE_BASE:     src_base_ff <= csr_data[ADDR_BITS-1:0];
            CSR_TARGET_BASE:     dst_base_ff <= csr_data[ADDR_BITS-1:0];
            default: ;   // writes beyond the register list are dropped
         endcase
      end
   end

   // effective sizes, lane 0 is the horizontal axis, lane 1 the vertical one
   // users change config only while the pipeline is empty; the block does not check
   logic [DIM_W-1:0] eff_src [2];
   logic [DIM_W-1:0] eff_dst [2];
   logic             mode_shrink, mode_enlarge;

   always_comb begin
      eff_src[0]   = eff_size(src_w_ff);
      eff_src[1]   = eff_size(src_h_ff);
      eff_dst[0]   = eff_size(dst_w_ff);
      eff_dst[1]   = eff_size(dst_h_ff);
      mode_shrink  = (eff_dst[0] <= eff_src[0]) && (eff_dst[1] <= eff_src[1]);
      mode_enlarge = (eff_dst[0] >  eff_src[0]) && (eff_dst[1] >  eff_src[1]);
   end

   // one restoring division step: bring in one dividend bit, subtract if it fits
   function automatic logic [DIM_W:0] div_step(input logic [DIM_W-1:0] rem,
                                                input logic             din,
                                                input logic [DIM_W-1:0] dvs);
      logic [DIM_W:0] t;
      logic [DIM_W:0] d;
      t = {rem, din};
      d = t - {1'b0, dvs};
      if (t >= {1'b0, dvs}) begin
         return {1'b1, d[DIM_W-1:0]};
      end
      return {1'b0, t[DIM_W-1:0]};
   endfunction

   // -------------------------------------------------------------------------
   // stall chain: a stage moves when it is empty or the next one moves
   // -------------------------------------------------------------------------
   logic [NSTG:1] vld_ff;
   logic [NSTG:1] adv;
   logic          entry_valid;

   always_comb begin
      adv[NSTG] = !vld_ff[NSTG] || !rsp_stall;
      for (int k = NSTG - 1; k >= 1; k--) begin
         adv[k] = !vld_ff[k] || adv[k+1];
      end
      req_stall   = !adv[1];
      // mixed scaling requests are taken and dropped here
      entry_valid = req_valid && (mode_shrink || mode_enlarge);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (adv[1]) begin
            vld_ff[1] <= entry_valid;
         end
         for (int k = 2; k <= NSTG; k++) begin
            if (adv[k]) begin
               vld_ff[k] <= vld_ff[k-1];
            end
         end
      end
   end

   // -------------------------------------------------------------------------
   // stage 1: centre the mapped coordinate, split into sign and magnitude
   // -------------------------------------------------------------------------
   logic               enl1_in, enl1_ff;
   logic [COORD_W-1:0] raw1_in [2];
   logic [COORD_W-1:0] raw1_ff [2];
   logic               neg1_in [2];
   logic               neg1_ff [2];
   logic [COORD_W-1:0] mag1_in [2];
   logic [COORD_W-1:0] mag1_ff [2];

   always_comb begin
      logic [DIM_W-1:0]   own;
      logic [COORD_W+1:0] diff;
      logic [COORD_W+1:0] absd;
      enl1_in    = mode_enlarge;
      raw1_in[0] = req_data.column;
      raw1_in[1] = req_data.line;
      for (int l = 0; l < 2; l++) begin
         own  = mode_enlarge ? eff_dst[l] : eff_src[l];
         diff = {2'b00, raw1_in[l]} - {2'b00, own[DIM_W-1:1]};
         absd = diff[COORD_W+1] ? (~diff + 1'b1) : diff;
         neg1_in[l] = diff[COORD_W+1];
         mag1_in[l] = absd[COORD_W-1:0];
      end
   end

   // -------------------------------------------------------------------------
   // stage 2: scale the magnitude by the other size
   // -------------------------------------------------------------------------
   logic               enl2_ff;
   logic [COORD_W-1:0] raw2_ff [2];
   logic               neg2_ff [2];
   logic [PROD_W-1:0]  prod2_in [2];
   logic [PROD_W-1:0]  prod2_ff [2];

   always_comb begin
      logic [DIM_W-1:0] other;
      for (int l = 0; l < 2; l++) begin
         other       = enl1_ff ? eff_src[l] : eff_dst[l];
         prod2_in[l] = PROD_W'(mag1_ff[l]) * PROD_W'(other);
      end
   end

   // -------------------------------------------------------------------------
   // stages 3 and 4: divide by the own size, six quotient bits each
   // the other size never exceeds the own size, so the quotient fits a coordinate
   // -------------------------------------------------------------------------
   logic               enl3_ff;
   logic [COORD_W-1:0] raw3_ff [2];
   logic               neg3_ff [2];
   logic [DIM_W-1:0]   rem3_in [2];
   logic [DIM_W-1:0]   rem3_ff [2];
   logic [HALF_Q-1:0]  qhi3_in [2];
   logic [HALF_Q-1:0]  qhi3_ff [2];
   logic [HALF_Q-1:0]  low3_ff [2];

   always_comb begin
      logic [DIM_W-1:0] own;
      logic [DIM_W-1:0] rem;
      logic [DIM_W:0]   st;
      for (int l = 0; l < 2; l++) begin
         own = enl2_ff ? eff_dst[l] : eff_src[l];
         rem = prod2_ff[l][PROD_W-1:COORD_W];
         for (int b = 0; b < HALF_Q; b++) begin
            st = div_step(rem, prod2_ff[l][COORD_W-1-b], own);
            qhi3_in[l][HALF_Q-1-b] = st[DIM_W];
            rem = st[DIM_W-1:0];
         end
         rem3_in[l] = rem;
      end
   end

   logic               enl4_ff;
   logic [COORD_W-1:0] raw4_ff [2];
   logic               neg4_ff [2];
   logic [COORD_W-1:0] quo4_in [2];
   logic [COORD_W-1:0] quo4_ff [2];

   always_comb begin
      logic [DIM_W-1:0]  own;
      logic [DIM_W-1:0]  rem;
      logic [DIM_W:0]    st;
      logic [HALF_Q-1:0] qlo;
      for (int l = 0; l < 2; l++) begin
         own = enl3_ff ? eff_dst[l] : eff_src[l];
         rem = rem3_ff[l];
         qlo = '0;
         for (int b = 0; b < HALF_Q; b++) begin
            st = div_step(rem, low3_ff[l][HALF_Q-1-b], own);
            qlo[HALF_Q-1-b] = st[DIM_W];
            rem = st[DIM_W-1:0];
         end
         quo4_in[l] = {qhi3_ff[l], qlo};
      end
   end

   // -------------------------------------------------------------------------
   // stage 5: restore the sign, re-centre and clamp to the other image
   // -------------------------------------------------------------------------
   logic               enl5_ff;
   logic [COORD_W-1:0] raw5_ff [2];
   logic [COORD_W-1:0] map5_in [2];
   logic [COORD_W-1:0] map5_ff [2];

   always_comb begin
      logic [DIM_W-1:0]   other;
      logic [DIM_W-1:0]   top;
      logic [COORD_W+2:0] sq;
      logic [COORD_W+2:0] pos;
      for (int l = 0; l < 2; l++) begin
         other = enl4_ff ? eff_src[l] : eff_dst[l];
         top   = other - 1'b1;
         sq    = {3'b000, quo4_ff[l]};
         if (neg4_ff[l]) begin
            sq = ~sq + 1'b1;
         end
         pos = sq + {3'b000, other[DIM_W-1:1]};
         if (pos[COORD_W+2]) begin
            map5_in[l] = '0;                        // left of the image
         end else if (pos > {2'b00, top}) begin
            map5_in[l] = top[COORD_W-1:0];          // right of the image
         end else begin
            map5_in[l] = pos[COORD_W-1:0];
         end
      end
   end

   // -------------------------------------------------------------------------
   // stage 6: pixel indexes, row times width plus column
   // shrink reads the request position and writes the mapped one; enlarge swaps
   // -------------------------------------------------------------------------
   logic             enl6_ff;
   logic [IDX_W-1:0] ridx6_in, ridx6_ff;
   logic [IDX_W-1:0] widx6_in, widx6_ff;

   always_comb begin
      logic [COORD_W-1:0] rcol, rrow, wcol, wrow;
      logic [IDX_W:0]     rsum, wsum;
      rcol = enl5_ff ? map5_ff[0] : raw5_ff[0];
      rrow = enl5_ff ? map5_ff[1] : raw5_ff[1];
      wcol = enl5_ff ? raw5_ff[0] : map5_ff[0];
      wrow = enl5_ff ? raw5_ff[1] : map5_ff[1];
      rsum = (IDX_W+1)'(rrow) * (IDX_W+1)'(eff_src[0]) + (IDX_W+1)'(rcol);
      wsum = (IDX_W+1)'(wrow) * (IDX_W+1)'(eff_dst[0]) + (IDX_W+1)'(wcol);
      ridx6_in = rsum[IDX_W-1:0];
      widx6_in = wsum[IDX_W-1:0];
   end

   // -------------------------------------------------------------------------
   // stage 7: byte addresses, wrapping at the address width; output register
   // -------------------------------------------------------------------------
   rsp_type rsp7_in, rsp7_ff;

   always_comb begin
      logic [SCL_W-1:0] rscl, wscl;
      rscl = SCL_W'(ridx6_ff) * SCL_W'(bpp_ff);
      wscl = SCL_W'(widx6_ff) * SCL_W'(bpp_ff);
      rsp7_in.read_address  = src_base_ff + ADDR_BITS'(rscl);
      rsp7_in.write_address = dst_base_ff + ADDR_BITS'(wscl);
      rsp7_in.enlarging     = enl6_ff;
   end

   // -------------------------------------------------------------------------
   // payload registers, loaded whenever their stage moves
   // -------------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (adv[1]) begin
         enl1_ff <= enl1_in;
         raw1_ff <= raw1_in;
         neg1_ff <= neg1_in;
         mag1_ff <= mag1_in;
      end
      if (adv[2]) begin
         enl2_ff  <= enl1_ff;
         raw2_ff  <= raw1_ff;
         neg2_ff  <= neg1_ff;
         prod2_ff <= prod2_in;
      end
      if (adv[3]) begin
         enl3_ff <= enl2_ff;
         raw3_ff <= raw2_ff;
         neg3_ff <= neg2_ff;
         rem3_ff <= rem3_in;
         qhi3_ff <= qhi3_in;
         for (int l = 0; l < 2; l++) begin
            low3_ff[l] <= prod2_ff[l][HALF_Q-1:0];
         end
      end
      if (adv[4]) begin
         enl4_ff <= enl3_ff;
         raw4_ff <= raw3_ff;
         neg4_ff <= neg3_ff;
         quo4_ff <= quo4_in;
      end
      if (adv[5]) begin
         enl5_ff <= enl4_ff;
         raw5_ff <= raw4_ff;
         map5_ff <= map5_in;
      end
      if (adv[6]) begin
         enl6_ff  <= enl5_ff;
         ridx6_ff <= ridx6_in;
         widx6_ff <= widx6_in;
      end
      if (adv[7]) begin
         rsp7_ff <= rsp7_in;
      end
   end

   assign rsp_valid = vld_ff[NSTG];
   assign rsp_data  = rsp7_ff;

endmodule : nearest_neighbor_scale_address
`default_nettype wire
